[rtl/u2u_pkg.sv]
package u2u_pkg;

  // result kinds
  localparam logic KindUnit   = 1'b0;
  localparam logic KindReport = 1'b1;

  // status codes on the end-of-stream report
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusLossy  = 2'd1;
  localparam logic [1:0] StatusNoRoom = 2'd2;

  // configuration register indexes
  localparam logic RegCapacity  = 1'b0;
  localparam logic RegCountOnly = 1'b1;

  // code point constants
  localparam logic [20:0] CpReplacement = 21'h00FFFD;
  localparam logic [20:0] CpMax         = 21'h10FFFF;
  localparam logic [20:0] CpSurLo       = 21'h00D800;
  localparam logic [20:0] CpSurHi       = 21'h00DFFF;
  localparam logic [20:0] CpSupp        = 21'h010000;
  localparam logic [15:0] HiSurBase     = 16'hD800;
  localparam logic [15:0] LoSurBase     = 16'hDC00;

  localparam int MaxResults = 3;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] code_unit;
    logic [1:0]  status_code;
    logic [31:0] written_bytes;
    logic        last_of_run;
  } out_t;

  typedef out_t [MaxResults-1:0] out_vec_t;

  // decoder and stream state
  typedef struct packed {
    logic [20:0] pcp;
    logic [1:0]  bse;
    logic [1:0]  seq;
    logic        lossy;
    logic        full;
    logic [31:0] count;
  } st_t;

  // smallest legal code point for a sequence with this many continuation bytes
  function automatic logic [20:0] min_cp(input logic [1:0] seq);
    logic [20:0] m;
    unique case (seq)
      2'd0:    m = 21'h000000;
      2'd1:    m = 21'h000080;
      2'd2:    m = 21'h000800;
      default: m = 21'h010000;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] unit_bytes(input logic [20:0] cp);
    return (cp >= CpSupp) ? 3'd4 : 3'd2;
  endfunction

  function automatic out_t mk_unit(input logic [15:0] u);
    out_t r;
    r               = '0;
    r.item_kind     = KindUnit;
    r.code_unit     = u;
    return r;
  endfunction

endpackage

[rtl/u2u_step.sv]
// per-byte decode, capacity check and result assembly
module u2u_step (
  input  u2u_pkg::st_t     st,
  input  u2u_pkg::in_t     item,
  input  logic [31:0]      capacity,
  input  logic             count_only,
  output u2u_pkg::st_t     st_nxt,
  output u2u_pkg::out_vec_t res,
  output logic [1:0]       res_cnt
);

  always_comb begin
    logic [20:0] acc;
    logic        cont;
    logic        lead_en;
    logic [7:0]  b;
    logic        v   [3];
    logic        bd  [3];
    logic [20:0] cps [3];
    logic [3:0]  s   [3];
    logic        fit [3];
    logic        em  [3];
    logic [3:0]  add;
    logic [32:0] sum;
    logic [32:0] tot;
    logic [19:0] off;
    logic [2:0]  pos;
    logic [1:0]  status;
    logic [31:0] written;
    u2u_pkg::out_t rep;

    st_nxt  = st;
    b       = item.data_byte;
    acc     = {st.pcp[14:0], b[5:0]};
    cont    = (b[7:6] == 2'b10);
    lead_en = 1'b0;
    for (int k = 0; k < 3; k++) begin
      v[k]   = 1'b0;
      bd[k]  = 1'b0;
      cps[k] = '0;
    end

    // continuation or broken sequence
    if (item.byte_present) begin
      if (st.bse != 2'd0) begin
        if (cont) begin
          st_nxt.bse = st.bse - 2'd1;
          st_nxt.pcp = acc;
          if (st.bse == 2'd1) begin
            v[0] = 1'b1;
            if (acc < u2u_pkg::min_cp(st.seq) || acc > u2u_pkg::CpMax ||
                (acc >= u2u_pkg::CpSurLo && acc <= u2u_pkg::CpSurHi)) begin
              bd[0]  = 1'b1;
              cps[0] = u2u_pkg::CpReplacement;
            end else begin
              cps[0] = acc;
            end
            st_nxt.pcp = '0;
            st_nxt.seq = '0;
          end
        end else begin
          v[0]       = 1'b1;
          bd[0]      = 1'b1;
          cps[0]     = u2u_pkg::CpReplacement;
          st_nxt.bse = '0;
          st_nxt.seq = '0;
          st_nxt.pcp = '0;
          lead_en    = 1'b1;
        end
      end else begin
        lead_en = 1'b1;
      end
    end

    // lead byte
    if (lead_en) begin
      if (!b[7]) begin
        v[1]   = 1'b1;
        cps[1] = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        st_nxt.pcp = {16'd0, b[4:0]};
        st_nxt.seq = 2'd1;
        st_nxt.bse = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        st_nxt.pcp = {17'd0, b[3:0]};
        st_nxt.seq = 2'd2;
        st_nxt.bse = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        st_nxt.pcp = {18'd0, b[2:0]};
        st_nxt.seq = 2'd3;
        st_nxt.bse = 2'd3;
      end else begin
        v[1]   = 1'b1;
        bd[1]  = 1'b1;
        cps[1] = u2u_pkg::CpReplacement;
      end
    end

    // sequence still open at end of stream
    if (item.end_of_source && st_nxt.bse != 2'd0) begin
      v[2]   = 1'b1;
      bd[2]  = 1'b1;
      cps[2] = u2u_pkg::CpReplacement;
    end

    // running byte totals; once one does not fit none after it can
    s[0] = v[0] ? {1'b0, u2u_pkg::unit_bytes(cps[0])} : 4'd0;
    s[1] = s[0] + (v[1] ? {1'b0, u2u_pkg::unit_bytes(cps[1])} : 4'd0);
    s[2] = s[1] + (v[2] ? {1'b0, u2u_pkg::unit_bytes(cps[2])} : 4'd0);
    add  = '0;
    for (int k = 0; k < 3; k++) begin
      tot    = {1'b0, st.count} + {29'd0, s[k]};
      fit[k] = !st.full && (count_only || tot <= {1'b0, capacity});
      em[k]  = v[k] && fit[k];
      if (v[k] && !fit[k]) begin
        st_nxt.full = 1'b1;
      end
      if (bd[k]) begin
        st_nxt.lossy = 1'b1;
      end
      if (em[k]) begin
        add = add + {1'b0, u2u_pkg::unit_bytes(cps[k])};
      end
    end
    sum          = {1'b0, st.count} + {29'd0, add};
    st_nxt.count = sum[32] ? '1 : sum[31:0];

    // lay out units, then the report
    res = '0;
    pos = '0;
    off = '0;
    for (int k = 0; k < 3; k++) begin
      if (em[k] && !count_only) begin
        if (cps[k] >= u2u_pkg::CpSupp) begin
          off = 20'(cps[k] - u2u_pkg::CpSupp);
          if (pos < 3'd3) begin
            res[pos[1:0]] = u2u_pkg::mk_unit(u2u_pkg::HiSurBase + {6'd0, off[19:10]});
          end
          pos = pos + 3'd1;
          if (pos < 3'd3) begin
            res[pos[1:0]] = u2u_pkg::mk_unit(u2u_pkg::LoSurBase + {6'd0, off[9:0]});
          end
          pos = pos + 3'd1;
        end else begin
          if (pos < 3'd3) begin
            res[pos[1:0]] = u2u_pkg::mk_unit(cps[k][15:0]);
          end
          pos = pos + 3'd1;
        end
      end
    end

    status  = st_nxt.full  ? u2u_pkg::StatusNoRoom :
              st_nxt.lossy ? u2u_pkg::StatusLossy  : u2u_pkg::StatusOk;
    written = st_nxt.count;
    rep               = '0;
    rep.item_kind     = u2u_pkg::KindReport;
    rep.status_code   = status;
    rep.written_bytes = written;
    if (item.end_of_source) begin
      if (pos < 3'd3) begin
        res[pos[1:0]] = rep;
      end
      pos    = pos + 3'd1;
      st_nxt = '0;
    end

    if (pos > 3'd3) begin
      pos = 3'd3;
    end
    if (pos != 3'd0) begin
      res[2'(pos - 3'd1)].last_of_run = 1'b1;
    end
    res_cnt = pos[1:0];
  end

endmodule

[rtl/u2u_queue.sv]
// result queue: takes up to three results in a cycle, hands out one per pop
module u2u_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  u2u_pkg::out_vec_t push_data,
  input  logic              pop,
  output u2u_pkg::out_t     head,
  output logic [2:0]        level
);

  localparam int Depth = u2u_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);

  u2u_pkg::out_t     mem [Depth];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [2:0]        cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    for (int k = 0; k < u2u_pkg::MaxResults; k++) begin
      if (2'(k) < push_cnt) begin
        mem[wp_r + PtrW'(k)] <= push_data[k];
      end
    end
  end

  assign cnt_nxt = cnt_r + {1'b0, push_cnt} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PtrW'(push_cnt);
      rp_r  <= rp_r + PtrW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = mem[rp_r];
  assign level = cnt_r;

endmodule

[rtl/utf8_to_utf16_decoder.sv]
// utf-8 to utf-16 transcoder. one utf-8 byte per request is registered, decoded in a
// single pass and its results (one or two utf-16 units, a u+fffd for malformed input,
// and on end of source a status report with the byte count) go into a four-entry
// result queue that drains one result per cycle while out_ready is high. a byte is
// taken every cycle as long as the queue has room for the results of the byte already
// held; a byte that makes two or three results may therefore hold the input while the
// queue drains. a request is held in the input register, its results in the result
// queue. configuration (capacity in bytes, count-only) is written through the cfg
// port between streams; count-only suppresses unit results and the capacity check.
module utf8_to_utf16_decoder (
  input  logic          clk,
  input  logic          rst_n,

  input  logic          in_valid,
  output logic          in_ready,
  input  u2u_pkg::in_t  in_data,

  output logic          out_valid,
  input  logic          out_ready,
  output u2u_pkg::out_t out_data,

  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_wdata
);

  // configuration registers
  logic [31:0] capacity_r;
  logic        count_only_r;

  // input register
  u2u_pkg::in_t item_r;
  logic         item_v_r;

  // stream state
  u2u_pkg::st_t st_r, st_nxt;

  u2u_pkg::out_vec_t res;
  logic [1:0]        res_cnt;
  logic [2:0]        level;
  logic [2:0]        room;
  logic              fire;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= '0;
      count_only_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        u2u_pkg::RegCapacity:  capacity_r   <= cfg_wdata;
        u2u_pkg::RegCountOnly: count_only_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  u2u_step u_step (
    .st         (st_r),
    .item       (item_r),
    .capacity   (capacity_r),
    .count_only (count_only_r),
    .st_nxt     (st_nxt),
    .res        (res),
    .res_cnt    (res_cnt)
  );

  // held byte goes once its results fit in the queue
  assign room     = 3'(u2u_pkg::QueueDepth) - level;
  assign fire     = item_v_r && ({1'b0, res_cnt} <= room);
  assign in_ready = !item_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_v_r <= 1'b1;
    end else if (fire) begin
      item_v_r <= 1'b0;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  assign pop = out_valid && out_ready;

  u2u_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (fire ? res_cnt : 2'd0),
    .push_data (res),
    .pop       (pop),
    .head      (out_data),
    .level     (level)
  );

  assign out_valid = (level != 3'd0);

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // generous ceiling on the run, well above the slowest legal schedule
  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  u2u_pkg::in_t in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  u2u_pkg::out_t out_data;

  logic cfg_we = 1'b0;
  logic cfg_index = u2u_pkg::RegCapacity;
  logic [31:0] cfg_wdata = '0;

  // requests waiting to be driven, and results still owed by the block
  u2u_pkg::in_t pending_reqs[$];
  u2u_pkg::out_t expected_results[$];
  u2u_pkg::out_t step_res[$];

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int fault_count = 0;
  int cycle_count = 0;
  int queued_reqs = 0;

  // shadow copy of the transcoder: registers first, then per-stream state
  logic [31:0] cap_reg = '0;
  logic count_only_reg = 1'b0;
  logic [20:0] cp_acc = '0;
  logic [1:0] cont_left = '0;
  logic [1:0] cont_total = '0;
  logic lossy_seen = 1'b0;
  logic stream_full = 1'b0;
  logic [31:0] utf16_bytes = '0;

  utf8_to_utf16_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // transcoder prediction
  // ---------------------------------------------------------------------

  // results beyond three per request cannot be carried by the block
  task automatic add_result(input logic kind, input logic [15:0] unit,
                            input logic [1:0] status, input logic [31:0] wbytes);
    u2u_pkg::out_t r;
    if (step_res.size() >= u2u_pkg::MaxResults) return;
    r = '0;
    r.item_kind = kind;
    r.code_unit = unit;
    r.status_code = status;
    r.written_bytes = wbytes;
    step_res.push_back(r);
  endtask

  // one code point out as a unit or a surrogate pair, subject to capacity
  task automatic emit_point(input logic [20:0] cp);
    logic [2:0] need;
    logic [32:0] sum;
    logic [19:0] off;
    need = (cp >= u2u_pkg::CpSupp) ? 3'd4 : 3'd2;
    if (stream_full) return;
    // a unit or pair that does not fit is dropped whole and latches full
    if (!count_only_reg && ({1'b0, utf16_bytes} + 33'(need) > {1'b0, cap_reg})) begin
      stream_full = 1'b1;
      return;
    end
    if (!count_only_reg) begin
      if (cp >= u2u_pkg::CpSupp) begin
        off = 20'(cp - u2u_pkg::CpSupp);
        add_result(u2u_pkg::KindUnit, u2u_pkg::HiSurBase + {6'd0, off[19:10]},
                   u2u_pkg::StatusOk, '0);
        add_result(u2u_pkg::KindUnit, u2u_pkg::LoSurBase + {6'd0, off[9:0]},
                   u2u_pkg::StatusOk, '0);
      end else begin
        add_result(u2u_pkg::KindUnit, cp[15:0], u2u_pkg::StatusOk, '0);
      end
    end
    sum = {1'b0, utf16_bytes} + 33'(need);
    utf16_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endtask

  task automatic flag_malformed();
    lossy_seen = 1'b1;
    emit_point(u2u_pkg::CpReplacement);
  endtask

  // lowest code point allowed for a given number of continuation bytes
  function automatic logic [20:0] seq_floor(input logic [1:0] n);
    case (n)
      2'd1:    return 21'h000080;
      2'd2:    return 21'h000800;
      default: return 21'h010000;
    endcase
  endfunction

  task automatic open_sequence(input logic [7:0] b);
    if (!b[7]) begin
      emit_point({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      cp_acc = {16'd0, b[4:0]};
      cont_total = 2'd1;
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc = {17'd0, b[3:0]};
      cont_total = 2'd2;
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc = {18'd0, b[2:0]};
      cont_total = 2'd3;
      cont_left = 2'd3;
    end else begin
      // stray continuation or a lead that no encoding uses
      flag_malformed();
    end
  endtask

  // works out every result of one accepted request, last one marked
  task automatic predict_request(input u2u_pkg::in_t req);
    logic [1:0] status;
    step_res.delete();
    if (req.byte_present) begin
      if (cont_left != 2'd0) begin
        if (req.data_byte[7:6] == 2'b10) begin
          cp_acc = {cp_acc[14:0], req.data_byte[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            // overlong, beyond the last plane, or a surrogate value
            if (cp_acc < seq_floor(cont_total) || cp_acc > u2u_pkg::CpMax ||
                (cp_acc >= u2u_pkg::CpSurLo && cp_acc <= u2u_pkg::CpSurHi))
              flag_malformed();
            else
              emit_point(cp_acc);
            cp_acc = '0;
            cont_total = '0;
          end
        end else begin
          // broken sequence: replacement, then the byte starts afresh
          cont_left = '0;
          cont_total = '0;
          cp_acc = '0;
          flag_malformed();
          open_sequence(req.data_byte);
        end
      end else begin
        open_sequence(req.data_byte);
      end
    end
    if (req.end_of_source) begin
      if (cont_left != 2'd0) flag_malformed();
      status = stream_full ? u2u_pkg::StatusNoRoom :
               (lossy_seen ? u2u_pkg::StatusLossy : u2u_pkg::StatusOk);
      add_result(u2u_pkg::KindReport, '0, status, utf16_bytes);
      cp_acc = '0;
      cont_left = '0;
      cont_total = '0;
      lossy_seen = 1'b0;
      stream_full = 1'b0;
      utf16_bytes = '0;
    end
    if (step_res.size() != 0) step_res[step_res.size()-1].last_of_run = 1'b1;
    foreach (step_res[i]) expected_results.push_back(step_res[i]);
  endtask

  // ---------------------------------------------------------------------
  // request driver: presents queued requests, predicts on acceptance
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_request(in_data);
      // only move on once the current request has gone, or none is up
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result monitor and receiver back-pressure
  // ---------------------------------------------------------------------
  task automatic log_fault(input string why, input u2u_pkg::out_t want,
                           input u2u_pkg::out_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%s: expected kind %0d unit %h status %0d written %0d last %0d",
               why, want.item_kind, want.code_unit, want.status_code,
               want.written_bytes, want.last_of_run,
               "  got kind %0d unit %h status %0d written %0d last %0d",
               got.item_kind, got.code_unit, got.status_code,
               got.written_bytes, got.last_of_run);
  endtask

  always @(posedge clk) begin : watch
    u2u_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        log_fault("unexpected result", '0, out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.item_kind !== want.item_kind ||
            out_data.code_unit !== want.code_unit ||
            out_data.status_code !== want.status_code ||
            out_data.written_bytes !== want.written_bytes ||
            out_data.last_of_run !== want.last_of_run)
          log_fault("result mismatch", want, out_data);
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // requests that neither carry a byte nor close the stream are ignored
  // by the block and so are not counted
  task automatic push_req(input logic [7:0] b, input logic present, input logic eos);
    u2u_pkg::in_t r;
    r.data_byte = b;
    r.byte_present = present;
    r.end_of_source = eos;
    pending_reqs.push_back(r);
    if (present || eos) queued_reqs++;
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // well-formed utf-8 for one code point
  task automatic encode_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_req(cp[7:0], 1'b1, 1'b0);
    end else if (cp < 21'h800) begin
      push_req({3'b110, cp[10:6]}, 1'b1, 1'b0);
      push_req({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end else if (cp < u2u_pkg::CpSupp) begin
      push_req({4'b1110, cp[15:12]}, 1'b1, 1'b0);
      push_req({2'b10, cp[11:6]}, 1'b1, 1'b0);
      push_req({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end else begin
      push_req({5'b11110, cp[20:18]}, 1'b1, 1'b0);
      push_req({2'b10, cp[17:12]}, 1'b1, 1'b0);
      push_req({2'b10, cp[11:6]}, 1'b1, 1'b0);
      push_req({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end
  endtask

  // mostly clean characters, the rest malformed in every way the
  // decoder distinguishes, then now and again an end of stream
  task automatic gen_unit(input int eos_pct);
    int pick;
    int k;
    logic [20:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 3))
        0: cp = 21'($urandom_range(0, 'h7F));
        1: cp = 21'($urandom_range('h80, 'h7FF));
        2: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          // steer clear of the surrogate block for clean characters
          if (cp >= u2u_pkg::CpSurLo && cp <= u2u_pkg::CpSurHi) cp = cp ^ 21'h8000;
        end
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      encode_point(cp);
    end else if (pick < 62) begin
      // truncated: lead with too few continuation bytes
      k = $urandom_range(2, 4);
      case (k)
        2:       push_req({3'b110, 5'($urandom)}, 1'b1, 1'b0);
        3:       push_req({4'b1110, 4'($urandom)}, 1'b1, 1'b0);
        default: push_req({5'b11110, 3'($urandom)}, 1'b1, 1'b0);
      endcase
      repeat ($urandom_range(0, k - 2)) push_req(cont_byte(), 1'b1, 1'b0);
    end else if (pick < 70) begin
      // overlong forms
      case ($urandom_range(0, 2))
        0: begin
          push_req(8'hC0 | 8'($urandom_range(0, 1)), 1'b1, 1'b0);
          push_req(cont_byte(), 1'b1, 1'b0);
        end
        1: begin
          push_req(8'hE0, 1'b1, 1'b0);
          push_req(8'h80 | 8'($urandom_range(0, 'h1F)), 1'b1, 1'b0);
          push_req(cont_byte(), 1'b1, 1'b0);
        end
        default: begin
          push_req(8'hF0, 1'b1, 1'b0);
          push_req(8'h80 | 8'($urandom_range(0, 'hF)), 1'b1, 1'b0);
          push_req(cont_byte(), 1'b1, 1'b0);
          push_req(cont_byte(), 1'b1, 1'b0);
        end
      endcase
    end else if (pick < 76) begin
      // encoded surrogate
      push_req(8'hED, 1'b1, 1'b0);
      push_req(8'hA0 | 8'($urandom_range(0, 'h1F)), 1'b1, 1'b0);
      push_req(cont_byte(), 1'b1, 1'b0);
    end else if (pick < 82) begin
      // beyond the last plane, including the unused four-byte leads
      if ($urandom_range(0, 1)) begin
        push_req(8'hF4, 1'b1, 1'b0);
        push_req(8'($urandom_range('h90, 'hBF)), 1'b1, 1'b0);
      end else begin
        push_req(8'($urandom_range('hF5, 'hF7)), 1'b1, 1'b0);
        push_req(cont_byte(), 1'b1, 1'b0);
      end
      push_req(cont_byte(), 1'b1, 1'b0);
      push_req(cont_byte(), 1'b1, 1'b0);
    end else if (pick < 88) begin
      // stray continuation or a lead with no encoding
      if ($urandom_range(0, 1)) push_req(cont_byte(), 1'b1, 1'b0);
      else push_req(8'($urandom_range('hF8, 'hFF)), 1'b1, 1'b0);
    end else if (pick < 95) begin
      push_req(8'($urandom), 1'b1, 1'b0);
    end else begin
      // no byte, no end: the block must simply swallow it
      push_req(8'($urandom), 1'b0, 1'b0);
    end
    if ($urandom_range(0, 99) < eos_pct) begin
      if ($urandom_range(0, 1) && pending_reqs[pending_reqs.size()-1].byte_present)
        pending_reqs[pending_reqs.size()-1].end_of_source = 1'b1;
      else
        push_req(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // register writes only while the block is idle
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == u2u_pkg::RegCapacity) cap_reg = value;
    else count_only_reg = value[0];
  endtask

  // sampled on the falling edge so every update of the rising edge is in;
  // the extra cycles cover a request still inside that owes no result
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic run_phase(input int n_reqs, input int eos_pct,
                           input int send_pct, input int stall_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    queued_reqs = 0;
    while (queued_reqs < n_reqs) gen_unit(eos_pct);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // widest buffer; upper bits of the count-only write are don't-care
    write_reg(u2u_pkg::RegCapacity, 32'hFFFF_FFFF);
    write_reg(u2u_pkg::RegCountOnly, {31'($urandom), 1'b0});
    @(negedge clk);

    // directed: ascii extremes, plane edges as surrogate pairs, report
    // with three results from the last byte
    push_req(8'h00, 1'b1, 1'b0);
    push_req(8'h7F, 1'b1, 1'b0);
    push_req(8'hC2, 1'b1, 1'b0);
    push_req(8'h80, 1'b1, 1'b0);
    push_req(8'hF0, 1'b1, 1'b0);
    push_req(8'h90, 1'b1, 1'b0);
    push_req(8'h80, 1'b1, 1'b0);
    push_req(8'h80, 1'b1, 1'b0);
    push_req(8'hF4, 1'b1, 1'b0);
    push_req(8'h8F, 1'b1, 1'b0);
    push_req(8'hBF, 1'b1, 1'b0);
    push_req(8'hBF, 1'b1, 1'b1);
    // stray continuation and an impossible lead
    push_req(8'h80, 1'b1, 1'b0);
    push_req(8'hFF, 1'b1, 1'b0);
    // overlong two-byte form
    push_req(8'hC0, 1'b1, 1'b0);
    push_req(8'hAF, 1'b1, 1'b0);
    // surrogate value
    push_req(8'hED, 1'b1, 1'b0);
    push_req(8'hA0, 1'b1, 1'b0);
    push_req(8'h80, 1'b1, 1'b0);
    // broken sequence: the 'A' is decoded again after the replacement
    push_req(8'hE2, 1'b1, 1'b0);
    push_req(8'h41, 1'b1, 1'b0);
    // sequence still open at end of stream
    push_req(8'hE1, 1'b1, 1'b0);
    push_req(8'h80, 1'b1, 1'b1);
    // ignored request, then an empty stream closed without a byte
    push_req(8'h5A, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b1);
    wait_drained();

    // random traffic under each idling pattern and several settings
    run_phase(30, 15, 77, 0);
    write_reg(u2u_pkg::RegCapacity, 32'($urandom_range(4, 24)));
    run_phase(30, 20, 0, 77);
    // count-only ignores capacity, even when it is zero
    write_reg(u2u_pkg::RegCapacity, 32'd0);
    write_reg(u2u_pkg::RegCountOnly, {31'($urandom), 1'b1});
    run_phase(30, 45, 32, 32);
    // zero capacity with a destination: any stream that produces a unit or a replacement ends up full
    write_reg(u2u_pkg::RegCountOnly, {31'($urandom), 1'b0});
    run_phase(12, 30, 0, 0);
    write_reg(u2u_pkg::RegCapacity, 32'($urandom_range(5, 60)));
    run_phase(20, 20, 32, 32);

    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      fault_count += expected_results.size();
    end
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
